// ----- rtl/postfix_regex_nfa_builder_defines.svh -----
// Assertion macros for the builder's top-level RTL file.
// Each macro expects i_clk in its scope; PRNB_ASSERT_NOW also expects i_rst_n.
`ifndef POSTFIX_REGEX_NFA_BUILDER_DEFINES_SVH
`define POSTFIX_REGEX_NFA_BUILDER_DEFINES_SVH

// Implication in the same cycle, checked outside reset.
`define PRNB_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, also checked across reset.
`define PRNB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/prnb_pkg.sv -----
// Shared types and constants for the postfix regular expression NFA builder.
// No dependencies; the front, queue, back and top files import this package.
package prnb_pkg;

    localparam int MAX_STATES  = 256;
    localparam int STACK_DEPTH = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam int STATE_W = $clog2(MAX_STATES);
    localparam int NEXT_W  = $clog2(MAX_STATES + 1);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int SP_W    = $clog2(STACK_DEPTH);
    localparam int QP_W    = $clog2(QUEUE_DEPTH);
    localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_EPS    = 8'd36;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_UNION  = 8'd43;
    localparam logic [7:0] CH_CONCAT = 8'd44;
    localparam logic [7:0] CH_SKIP   = 8'd46;
    localparam logic [7:0] CH_DIG_LO = 8'd48;
    localparam logic [7:0] CH_DIG_HI = 8'd57;
    localparam logic [7:0] CH_UC_LO  = 8'd65;
    localparam logic [7:0] CH_UC_HI  = 8'd90;
    localparam logic [7:0] CH_LC_LO  = 8'd97;
    localparam logic [7:0] CH_LC_HI  = 8'd122;

    localparam logic [2:0] K_WRITE = 3'd0;
    localparam logic [2:0] K_DONE  = 3'd1;
    localparam logic [2:0] K_BAD   = 3'd2;
    localparam logic [2:0] K_UNDER = 3'd3;
    localparam logic [2:0] K_CAP   = 3'd4;

    typedef enum logic [2:0] {
        OP_OPND     = 3'd0,
        OP_STAR     = 3'd1,
        OP_UNION    = 3'd2,
        OP_CONCAT   = 3'd3,
        OP_SKIPLAST = 3'd4,
        OP_ERR      = 3'd5
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [7:0]         tok;
        logic [STATE_W-1:0] n;
        logic [CNT_W-1:0]   count;
        logic               last;
        logic [2:0]         err;
    } t_cmd;

    // The flag is set when the end state's first slot is already taken.
    typedef struct packed {
        logic [STATE_W-1:0] s;
        logic [STATE_W-1:0] e;
        logic               f;
    } t_frag;

endpackage

// ----- rtl/prnb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module prnb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/prnb_fifo.sv -----
// Short command queue between the front and back parts of the builder.
// Depends on prnb_pkg for the command type and depth.
module prnb_fifo import prnb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    input  logic i_rd,
    output t_cmd o_rdata,
    output logic o_empty,
    output logic o_full
);

    t_cmd            r_q [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wp, n_wp;
    logic [QP_W-1:0] r_rp, n_rp;
    logic [QC_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr) begin
            n_wp = r_wp + QP_W'(1);
        end
        if (i_rd) begin
            n_rp = r_rp + QP_W'(1);
        end
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wp] <= i_wdata;
        end
    end

    assign o_rdata = r_q[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QC_W'(QUEUE_DEPTH));

endmodule

// ----- rtl/prnb_front.sv -----
// Front part: classifies each token, tracks stack depth and state numbering,
// detects errors and issues commands to the queue. Depends on prnb_pkg.
module prnb_front import prnb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_token,
    input  logic       i_is_last,
    output logic       o_wr,
    output t_cmd       o_cmd
);

    logic [CNT_W-1:0]  r_count, n_count;
    logic [NEXT_W-1:0] r_next, n_next;
    logic              r_discard, n_discard;

    logic       w_opnd, w_star, w_union, w_concat, w_skip;
    logic       w_room;
    logic [2:0] w_err;

    always_comb begin
        w_opnd   = i_token inside {CH_EPS, [CH_DIG_LO:CH_DIG_HI], [CH_UC_LO:CH_UC_HI],
                                   [CH_LC_LO:CH_LC_HI]};
        w_star   = (i_token == CH_STAR);
        w_union  = (i_token == CH_UNION);
        w_concat = (i_token == CH_CONCAT);
        w_skip   = (i_token == CH_SKIP);
        w_room   = (r_next <= NEXT_W'(MAX_STATES - 2));
    end

    always_comb begin
        n_count   = r_count;
        n_next    = r_next;
        n_discard = r_discard;
        o_wr      = 1'b0;
        w_err     = K_WRITE;
        o_cmd.op    = OP_ERR;
        o_cmd.tok   = i_token;
        o_cmd.n     = r_next[STATE_W-1:0];
        o_cmd.count = r_count;
        o_cmd.last  = i_is_last;
        o_cmd.err   = K_WRITE;
        if (i_accept) begin
            if (r_discard) begin
                if (i_is_last) begin
                    n_count   = '0;
                    n_next    = '0;
                    n_discard = 1'b0;
                end
            end else begin
                if (w_opnd) begin
                    if (r_count >= CNT_W'(STACK_DEPTH) || !w_room) begin
                        w_err = K_CAP;
                    end
                end else if (w_star) begin
                    if (r_count < CNT_W'(1)) begin
                        w_err = K_UNDER;
                    end else if (!w_room) begin
                        w_err = K_CAP;
                    end
                end else if (w_union) begin
                    if (r_count < CNT_W'(2)) begin
                        w_err = K_UNDER;
                    end else if (!w_room) begin
                        w_err = K_CAP;
                    end
                end else if (w_concat) begin
                    if (r_count < CNT_W'(2)) begin
                        w_err = K_UNDER;
                    end
                end else if (!w_skip) begin
                    w_err = K_BAD;
                end

                if (w_err == K_WRITE) begin
                    if (w_opnd) begin
                        o_wr     = 1'b1;
                        o_cmd.op = OP_OPND;
                        n_count  = r_count + CNT_W'(1);
                        n_next   = r_next + NEXT_W'(2);
                    end else if (w_star) begin
                        o_wr     = 1'b1;
                        o_cmd.op = OP_STAR;
                        n_next   = r_next + NEXT_W'(2);
                    end else if (w_union) begin
                        o_wr     = 1'b1;
                        o_cmd.op = OP_UNION;
                        n_count  = r_count - CNT_W'(1);
                        n_next   = r_next + NEXT_W'(2);
                    end else if (w_concat) begin
                        o_wr     = 1'b1;
                        o_cmd.op = OP_CONCAT;
                        n_count  = r_count - CNT_W'(1);
                    end else if (i_is_last) begin
                        if (r_count == '0) begin
                            w_err = K_UNDER;
                        end else begin
                            o_wr     = 1'b1;
                            o_cmd.op = OP_SKIPLAST;
                        end
                    end
                    if (w_err == K_WRITE && i_is_last) begin
                        n_count = '0;
                        n_next  = '0;
                    end
                end

                if (w_err != K_WRITE) begin
                    o_wr      = 1'b1;
                    o_cmd.op  = OP_ERR;
                    o_cmd.err = w_err;
                    n_count   = r_count;
                    n_next    = r_next;
                    if (i_is_last) begin
                        n_count = '0;
                        n_next  = '0;
                    end else begin
                        n_discard = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_next    <= '0;
            r_discard <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_next    <= n_next;
            r_discard <= n_discard;
        end
    end

endmodule

// ----- rtl/prnb_back.sv -----
// Back part: executes queued commands, keeps the fragment stack (top in a
// register, the rest in RAM) and, unless the output is stalled, emits one result
// per cycle into the output register. Depends on prnb_pkg and prnb_ram.
module prnb_back import prnb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_cmd               i_cmd,
    output logic               o_rd,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_kind,
    output logic [STATE_W-1:0] o_from_state,
    output logic [7:0]         o_label,
    output logic [STATE_W-1:0] o_target_state,
    output logic               o_slot,
    output logic               o_run_end
);

    typedef enum logic [1:0] {
        BS_IDLE = 2'b01,
        BS_RUN  = 2'b10
    } t_bstate;

    t_bstate r_bst, n_bst;
    t_cmd    r_cmd;
    logic [2:0] r_step;
    t_frag   r_top;
    logic    r_byp;
    t_frag   r_byp_data;

    logic               r_out_valid;
    logic [2:0]         r_kind;
    logic [STATE_W-1:0] r_from;
    logic [7:0]         r_label;
    logic [STATE_W-1:0] r_target;
    logic               r_slot;
    logic               r_run_end;

    logic [$bits(t_frag)-1:0] w_rdata;
    t_frag              w_sec, w_new_top;
    logic [STATE_W-1:0] w_n1;
    logic [2:0]         w_nw, w_last_step;
    logic               w_done_step, w_out_free, w_emit, w_fin, w_load;
    logic               w_we, w_re;
    logic [SP_W-1:0]    w_waddr, w_raddr;
    logic [CNT_W-1:0]   w_wcnt, w_rcnt;
    logic [2:0]         w_kind;
    logic [STATE_W-1:0] w_from, w_target;
    logic [7:0]         w_label;
    logic               w_slot;

    assign w_sec = r_byp ? r_byp_data : t_frag'(w_rdata);
    assign w_n1  = r_cmd.n + STATE_W'(1);

    always_comb begin
        case (r_cmd.op)
            OP_OPND:   w_nw = 3'd1;
            OP_STAR:   w_nw = 3'd4;
            OP_UNION:  w_nw = 3'd4;
            OP_CONCAT: w_nw = 3'd1;
            default:   w_nw = 3'd0;
        endcase
        if (r_cmd.op == OP_ERR) begin
            w_last_step = 3'd0;
        end else begin
            w_last_step = w_nw + {2'b00, r_cmd.last} - 3'd1;
        end
        w_done_step = (r_cmd.op != OP_ERR) && (r_step == w_nw);
    end

    always_comb begin
        case (r_cmd.op)
            OP_OPND:   w_new_top = '{s: r_cmd.n, e: w_n1, f: 1'b0};
            OP_STAR:   w_new_top = '{s: r_cmd.n, e: w_n1, f: 1'b1};
            OP_UNION:  w_new_top = '{s: r_cmd.n, e: w_n1, f: 1'b0};
            OP_CONCAT: w_new_top = '{s: w_sec.s, e: r_top.e, f: r_top.f};
            default:   w_new_top = r_top;
        endcase
    end

    always_comb begin
        w_kind   = K_WRITE;
        w_from   = r_cmd.n;
        w_label  = CH_EPS;
        w_target = w_n1;
        w_slot   = 1'b0;
        if (w_done_step) begin
            w_kind   = K_DONE;
            w_from   = w_new_top.s;
            w_label  = 8'd0;
            w_target = w_new_top.e;
        end else begin
            case (r_cmd.op)
                OP_OPND: begin
                    w_label = r_cmd.tok;
                end
                OP_STAR: begin
                    case (r_step)
                        3'd0: w_target = r_top.s;
                        3'd1: w_slot = 1'b1;
                        3'd2: begin
                            w_from = r_top.e;
                            w_slot = r_top.f;
                        end
                        default: begin
                            w_from   = w_n1;
                            w_target = r_cmd.n;
                        end
                    endcase
                end
                OP_UNION: begin
                    case (r_step)
                        3'd0: w_target = r_top.s;
                        3'd1: begin
                            w_target = w_sec.s;
                            w_slot   = 1'b1;
                        end
                        3'd2: begin
                            w_from = r_top.e;
                            w_slot = r_top.f;
                        end
                        default: begin
                            w_from = w_sec.e;
                            w_slot = w_sec.f;
                        end
                    endcase
                end
                OP_CONCAT: begin
                    w_from   = w_sec.e;
                    w_target = r_top.s;
                    w_slot   = w_sec.f;
                end
                default: begin
                    w_kind   = r_cmd.err;
                    w_from   = '0;
                    w_label  = r_cmd.tok;
                    w_target = '0;
                end
            endcase
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = (r_bst == BS_RUN) && w_out_free;
    assign w_fin      = w_emit && (r_step == w_last_step);
    assign w_load     = !i_empty && ((r_bst == BS_IDLE) || w_fin);
    assign o_rd       = w_load;

    // The old top moves into RAM when an operand pushes over a non-empty stack.
    assign w_wcnt  = r_cmd.count - CNT_W'(1);
    assign w_waddr = w_wcnt[SP_W-1:0];
    assign w_we    = w_fin && (r_cmd.op == OP_OPND) && (r_cmd.count != '0);
    assign w_rcnt  = i_cmd.count - CNT_W'(2);
    assign w_raddr = w_rcnt[SP_W-1:0];
    assign w_re    = w_load && (i_cmd.op == OP_UNION || i_cmd.op == OP_CONCAT);

    prnb_ram #(
        .WIDTH ($bits(t_frag)),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_top),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_bst = r_bst;
        if (w_load) begin
            n_bst = BS_RUN;
        end else if (w_fin) begin
            n_bst = BS_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bst       <= BS_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_byp       <= 1'b0;
        end else begin
            r_bst <= n_bst;
            if (w_load) begin
                r_step <= '0;
            end else if (w_emit) begin
                r_step <= r_step + 3'd1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_re) begin
                r_byp <= w_we && (w_waddr == w_raddr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_cmd;
        end
        if (w_fin) begin
            r_top <= w_new_top;
        end
        if (w_re) begin
            r_byp_data <= r_top;
        end
        if (w_emit) begin
            r_kind    <= w_kind;
            r_from    <= w_from;
            r_label   <= w_label;
            r_target  <= w_target;
            r_slot    <= w_slot;
            r_run_end <= (r_step == w_last_step);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_from_state   = r_from;
    assign o_label        = r_label;
    assign o_target_state = r_target;
    assign o_slot         = r_slot;
    assign o_run_end      = r_run_end;

endmodule

// ----- rtl/postfix_regex_nfa_builder.sv -----
// Top level of the postfix regular expression to epsilon-NFA builder.
// Depends on prnb_pkg, prnb_front, prnb_fifo, prnb_back and the defines header.
//
//   channel   direction  handshake                payload
//   input     in         i_in_valid / o_in_stall  i_token, i_is_last
//   output    out        o_out_valid / i_out_stall o_kind, o_from_state, o_label,
//                                                 o_target_state, o_slot, o_run_end
//
// An operand or concatenation yields one result in the back part, a star or union
// four, and a last token one more for its done result; an error yields one.
// Unless stalled, the back part emits one result per cycle; result counts set the rate.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// o_in_stall rises only when the four-entry command queue is full.
`include "postfix_regex_nfa_builder_defines.svh"

module postfix_regex_nfa_builder import prnb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_token,
    input  logic               i_is_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_kind,
    output logic [STATE_W-1:0] o_from_state,
    output logic [7:0]         o_label,
    output logic [STATE_W-1:0] o_target_state,
    output logic               o_slot,
    output logic               o_run_end
);

    logic w_accept, w_wr, w_rd, w_empty, w_full;
    t_cmd w_wcmd, w_rcmd;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    prnb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_token   (i_token),
        .i_is_last (i_is_last),
        .o_wr      (w_wr),
        .o_cmd     (w_wcmd)
    );

    prnb_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_wdata (w_wcmd),
        .i_rd    (w_rd),
        .o_rdata (w_rcmd),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    prnb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_cmd          (w_rcmd),
        .o_rd           (w_rd),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_from_state   (o_from_state),
        .o_label        (o_label),
        .o_target_state (o_target_state),
        .o_slot         (o_slot),
        .o_run_end      (o_run_end)
    );

    `PRNB_ASSERT_NOW(a_no_write_when_full, w_wr, !w_full, "command written into a full queue")
    `PRNB_ASSERT_NOW(a_end_on_final, o_out_valid && o_kind != K_WRITE, o_run_end, "done or error result without run end")
    `PRNB_ASSERT_NEXT(a_reset_clears_out, !i_rst_n, !o_out_valid, "result valid straight after reset")

endmodule
